// ===== src/csfnv_pkg.sv =====
// Shared constants, types and the FNV prime multiply for the chunk seed hash.
`default_nettype none
package csfnv_pkg;

    localparam int unsigned HASH_W    = 64;
    localparam int unsigned COORD_W   = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned MSG_BYTES = 20;
    localparam int unsigned MSG_W     = MSG_BYTES * BYTE_W;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    // Word moved from one cell to the next every cycle
    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
        logic [MSG_W-1:0]  msg;
    } cell_bus_t;

    // Multiply by the FNV prime 2^40 + 0x1B3 modulo 2^64, as a shift-add tree
    function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] h);
        fnv_mul = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
    endfunction

endpackage
`default_nettype wire

// ===== src/chunk_seed_fnv1a64_core.sv =====
// Top level of the chunk seed hash: configuration register and the row of round cells.
//
// Usage:
//   Configuration: cfg_data is written into the world seed register on a beat
//   of cfg_valid and cfg_ready. cfg_ready is always high. Write it only while
//   no item is in flight.
//   Input: a coordinate pair (chunk_x, chunk_z) is taken at each clock edge
//   where start is high and busy is low. busy is set while in reset and is cleared
//   by its register once reset is released; afterwards a pair can be taken
//   every cycle. Output: done pulses for one cycle with chunk_seed once the pair
//   has passed the registers of all cells, one result per pair, in order.
//   The 20-byte message runs through a row of 20 cells, one per message byte,
//   each doing one xor and one multiply by the FNV prime. Throughput is one
//   pair per cycle.
//   Reset clears the world seed to zero and empties the row; nothing is
//   lost to stalls as the receiver always takes the result.
`default_nettype none
module chunk_seed_fnv1a64_core
    import csfnv_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic signed [HASH_W-1:0]  cfg_data,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [COORD_W-1:0] chunk_x,
    input  wire logic signed [COORD_W-1:0] chunk_z,
    output logic                           done,
    output logic signed [HASH_W-1:0]       chunk_seed
);

    logic [HASH_W-1:0] world_seed_reg;
    logic              busy_reg;
    cell_bus_t         chain [0:MSG_BYTES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_seed_reg <= '0;
            busy_reg       <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                world_seed_reg <= $unsigned(cfg_data);
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = busy_reg;

    // Byte 0 is the seed LSB; x is padded to eight bytes with zeros
    assign chain[0] = '{
        valid: start && !busy_reg,
        hash:  FNV_BASIS,
        msg:   {$unsigned(chunk_z), {COORD_W{1'b0}}, $unsigned(chunk_x), world_seed_reg}
    };

    for (genvar i = 0; i < MSG_BYTES; i++)
    begin : g_cell
        csfnv_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bus_in  (chain[i]),
            .bus_out (chain[i+1])
        );
    end

    assign done       = chain[MSG_BYTES].valid;
    assign chunk_seed = $signed(chain[MSG_BYTES].hash);

endmodule
`default_nettype wire

// ===== src/csfnv_cell.sv =====
// One FNV-1a byte round: folds in the lowest message byte and hands on to the next cell.
`default_nettype none
module csfnv_cell
    import csfnv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_bus_t bus_in,
    output cell_bus_t      bus_out
);

    logic              valid_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [MSG_W-1:0]  msg_reg;
    logic [MSG_W-1:0]  msg_next;

    always_comb
    begin
        hash_next = fnv_mul(bus_in.hash ^ {{(HASH_W-BYTE_W){1'b0}}, bus_in.msg[BYTE_W-1:0]});
        msg_next  = bus_in.msg >> BYTE_W;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= bus_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        msg_reg  <= msg_next;
    end

    assign bus_out = '{valid: valid_reg, hash: hash_reg, msg: msg_reg};

endmodule
`default_nettype wire

// ===== src/csfnv_checker.sv =====
// Port-level checks on the chunk seed hash, bound to the top level.
`default_nettype none
module csfnv_checker
    import csfnv_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      cfg_valid,
    input wire logic                      cfg_ready,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic signed [COORD_W-1:0] chunk_x,
    input wire logic signed [COORD_W-1:0] chunk_z,
    input wire logic                      done,
    input wire logic signed [HASH_W-1:0]  chunk_seed
);

    localparam int unsigned LAT = MSG_BYTES;

    // Every result traces back to an earlier input beat
    a_done_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching input beat");

    // Every beat yields a result
    a_beat_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("input beat lost");

    // Once out of reset the block never holds off input
    a_busy_stays_low: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose outside reset");

    // Same coordinates on back-to-back beats with an unchanged seed give the same result
    a_same_in_same_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && $past(start && !busy) && $stable(chunk_x) && $stable(chunk_z)
            && !$past(cfg_valid && cfg_ready))
        |-> ##LAT (done && $stable(chunk_seed)))
        else $error("identical inputs hashed differently");

endmodule

bind chunk_seed_fnv1a64_core csfnv_checker u_csfnv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .start      (start),
    .busy       (busy),
    .chunk_x    (chunk_x),
    .chunk_z    (chunk_z),
    .done       (done),
    .chunk_seed (chunk_seed)
);
`default_nettype wire
